// ===== rtl/bidt_pkg.sv =====
`default_nettype none

package bidt_pkg;

  localparam int unsigned TableSize = 64;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned IdW       = 7;
  localparam int unsigned HandleW   = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FIND   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [IdW-1:0]       slot_id;
    logic [HandleW-1:0]   handle_in;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [IdW-1:0]       id_out;
    logic [HandleW-1:0]   handle_out;
    logic                 present;
    logic                 space_left;
  } rsp_t;

  typedef struct packed {
    logic                 found;
    logic [IdxW-1:0]      idx;
  } pick_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_id_table.sv =====
// path: an accepted item passes the result stage (p_q) and then the output
//   register (out_q), which drives out_valid_o and out_rsp_o
// throughput: one item per cycle while the output side keeps taking results;
//   set by the registered read of the handle memory and the single result stage
// reset: rst_ni clears the occupancy map and all valid flags; the handle memory
//   is not reset, its entries are only read while their slot is occupied
`default_nettype none

module bitmap_id_table import bidt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire req_t in_req_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output rsp_t      out_rsp_o,
  input  wire logic out_stall_i
);

  // lowest set bit of a map, as an index plus a found flag
  function automatic pick_t lowest_set(input logic [TableSize-1:0] v);
    logic [TableSize-1:0] onehot;
    pick_t                res;
    onehot    = v & (~v + TableSize'(1));
    res.found = |v;
    res.idx   = '0;
    for (int i = 0; i < TableSize; i++) begin
      res.idx = res.idx | (onehot[i] ? IdxW'(i) : '0);
    end
    return res;
  endfunction

  // occupancy map lives in flops, handles in a synchronous ram
  logic [TableSize-1:0] map_q, map_d;
  logic [HandleW-1:0]   mem [TableSize];
  logic [HandleW-1:0]   rdata_q;

  // result stage waiting for the ram read, then the output register
  logic p_valid_q, p_valid_d;
  rsp_t p_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  logic                 in_acc;
  logic                 p_move;
  logic                 id_ok;
  logic [IdxW-1:0]      idx;
  logic [TableSize-1:0] find_vec;
  pick_t                free_pick;
  pick_t                find_pick;
  rsp_t                 rsp;
  logic                 mem_we;
  logic                 mem_re;

  // the result stage moves on whenever the output register is empty or drained
  assign p_move     = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  // one-based id check and slot index
  assign id_ok = (in_req_i.slot_id != '0) && (in_req_i.slot_id <= IdW'(TableSize));
  assign idx   = id_ok ? IdxW'(in_req_i.slot_id - IdW'(1)) : '0;

  // search spaces: free slots for add, occupied slots at or above idx for find-next
  assign find_vec  = map_q & ({TableSize{1'b1}} << idx);
  assign free_pick = lowest_set(~map_q);
  assign find_pick = lowest_set(find_vec);

  // operation decode, map update and ram control
  always_comb begin
    map_d  = map_q;
    rsp    = '0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    rsp.status = ST_OK;
    case (in_req_i.req_type)
      REQ_ADD: begin
        if (!free_pick.found) begin
          rsp.status = ST_FULL;
        end else begin
          map_d[free_pick.idx] = 1'b1;
          rsp.id_out           = IdW'(free_pick.idx) + IdW'(1);
          mem_we               = in_acc;
        end
      end
      REQ_LOOKUP: begin
        if (!id_ok) begin
          rsp.status = ST_RANGE;
        end else if (map_q[idx]) begin
          rsp.present = 1'b1;
          mem_re      = in_acc;
        end
      end
      REQ_REMOVE: begin
        if (!id_ok) begin
          rsp.status = ST_RANGE;
        end else begin
          map_d[idx] = 1'b0;
        end
      end
      REQ_FIND: begin
        if (!id_ok) begin
          rsp.status = ST_RANGE;
        end else if (find_pick.found) begin
          rsp.id_out = IdW'(find_pick.idx) + IdW'(1);
        end else begin
          rsp.status = ST_NONE;
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase
    rsp.space_left = ~&map_d;
  end

  // handle ram: write on add, registered read on a lookup hit; a write and a
  // read never target the same cycle since at most one item is taken per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[free_pick.idx] <= in_req_i.handle_in;
    end
    if (mem_re) begin
      rdata_q <= mem[idx];
    end
  end

  always_comb begin
    p_valid_d = p_valid_q;
    if (in_acc) begin
      p_valid_d = 1'b1;
    end else if (p_move) begin
      p_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (p_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // the ram data joins the waiting result on its way out
  always_comb begin
    out_d            = p_q;
    out_d.handle_out = p_q.present ? rdata_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        map_q <= map_d;
      end
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers; rdata_q holds while the result stage waits since no
  // new item is taken then
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q <= rsp;
    end
    if (p_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  // a result waiting in the first stage carries the map's current free state
  a_space_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (p_q.space_left == ~&map_q))
    else $error("space_left does not match occupancy map");

  // an add that found room leaves its slot marked occupied
  a_add_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_req_i.req_type == REQ_ADD) && free_pick.found)
      |=> map_q[$past(free_pick.idx)])
    else $error("add did not set occupancy bit");

  // the input only stalls when both result registers are full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (p_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // a handle is only returned for a lookup hit
  a_handle_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.present || (out_rsp_o.handle_out == '0)))
    else $error("handle returned without a hit");
`endif

endmodule

`default_nettype wire
